>>> rtl/core/cpbq_pkg.sv
`default_nettype none
package cpbq_pkg;

  // fixed field widths
  localparam int WEIGHT_W = 16;
  localparam int CODE_W   = 8;
  localparam int SCALE_W  = 24;
  localparam int POS_W    = 6;
  localparam int SUM_W    = 21;

  // |weight| * 127 fits in this many bits
  localparam int PROD_W   = WEIGHT_W + 7;
  localparam int CODE_MAX = 127;

  // parameter defaults
  localparam int COLUMN_MAX_DEF       = 32;
  localparam int SCALE_EXTRA_BITS_DEF = 8;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_scale;
    logic scale_latch;
    logic rd;
    logic div_code;
    logic code_latch;
    logic next;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic col_end;
    logic div_done;
    logic use_div;
    logic idx_last;
    logic sal_mode;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/cpbq_div.sv
`default_nettype none
module cpbq_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W:0]        quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   shifted, diff, twice;
  logic             round_up;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_r, q_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    if (shifted >= {1'b0, den_r}) begin
      rem_nxt = diff[DEN_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DEN_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  // round half to even
  assign twice    = {rem_r, 1'b0};
  assign round_up = (twice > {1'b0, den_r}) || ((twice == {1'b0, den_r}) && q_r[0]);
  assign quo      = {1'b0, q_r} + (NUM_W+1)'(round_up);
  assign done     = done_r;

endmodule
`default_nettype wire

>>> rtl/core/cpbq_dp.sv
`default_nettype none
module cpbq_dp import cpbq_pkg::*; #(
  parameter int COLUMN_MAX       = COLUMN_MAX_DEF,
  parameter int SCALE_EXTRA_BITS = SCALE_EXTRA_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic signed [WEIGHT_W-1:0] in_weight,
  input  wire logic                       in_salient,
  input  wire logic                       in_last,
  input  wire cmd_t                       cmd,
  output sts_t                            sts,
  output logic signed [CODE_W-1:0]        out_code,
  output logic [SCALE_W-1:0]              out_scale,
  output logic [POS_W-1:0]                out_position,
  output logic                            out_final_res
);

  localparam int IDX_W   = (COLUMN_MAX > 1) ? $clog2(COLUMN_MAX) : 1;
  localparam int CNT_W   = $clog2(COLUMN_MAX + 1);
  localparam int SUMSH_W = SUM_W + SCALE_EXTRA_BITS;
  localparam int NUM_W   = (SUMSH_W > PROD_W) ? SUMSH_W : PROD_W;

  // salient scale by reciprocal multiplication: floor((peak << E + 63) / 127)
  localparam int SCLN_W   = WEIGHT_W + SCALE_EXTRA_BITS;
  localparam int RECIP_SH = SCLN_W + 7;
  localparam int RECIP_W  = SCLN_W + 1;
  localparam int SPROD_W  = SCLN_W + RECIP_W;
  localparam int SQ_W     = SCLN_W - 6;
  localparam int SQX_W    = (SQ_W > SCALE_W) ? SQ_W : SCALE_W;
  localparam longint unsigned RECIP_LL = ((64'd1 << RECIP_SH) + 64'd126) / 64'd127;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_LL);

  logic [WEIGHT_W-1:0] store [COLUMN_MAX];
  logic [WEIGHT_W-1:0] rdata_r;
  logic [CNT_W-1:0]    count_r;
  logic [IDX_W-1:0]    idx_r;
  logic [WEIGHT_W-1:0] peak_r;
  logic [SUM_W-1:0]    sum_r;
  logic                mode_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [CODE_W-1:0]   code_r, code_nxt;

  logic [WEIGHT_W-1:0] mag_in, mag_rd;
  logic [SUM_W:0]      sum_wide;
  logic [PROD_W-1:0]   prod;
  logic [NUM_W-1:0]    div_num;
  logic [WEIGHT_W-1:0] div_den;
  logic                div_done;
  logic [NUM_W:0]      div_quo;
  logic [CODE_W-1:0]   q8, code_div;
  logic                rd_neg, idx_last;
  logic [SCLN_W-1:0]   sal_num;
  logic [SPROD_W-1:0]  sal_prod;
  logic [SQX_W-1:0]    sal_ext;
  logic [SCALE_W-1:0]  sal_scale, bin_scale;

  assign mag_in   = in_weight[WEIGHT_W-1] ? WEIGHT_W'(-in_weight) : in_weight;
  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(mag_in);

  // column counters and running peak / sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      peak_r  <= '0;
      sum_r   <= '0;
      mode_r  <= 1'b0;
    end else if (cmd.load) begin
      count_r <= count_r + 1'b1;
      if (count_r == '0) begin
        mode_r <= in_salient;
      end
      if (mag_in > peak_r) begin
        peak_r <= mag_in;
      end
      sum_r <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    end else if (cmd.next) begin
      if (idx_last) begin
        idx_r   <= '0;
        count_r <= '0;
        peak_r  <= '0;
        sum_r   <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // column buffer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store[count_r[IDX_W-1:0]] <= in_weight;
    end
    if (cmd.rd) begin
      rdata_r <= store[idx_r];
    end
  end

  // divider operand select
  assign rd_neg = rdata_r[WEIGHT_W-1];
  assign mag_rd = rd_neg ? WEIGHT_W'(-rdata_r) : rdata_r;
  assign prod   = PROD_W'(mag_rd) * PROD_W'(CODE_MAX);

  always_comb begin
    if (cmd.div_code) begin
      div_num = NUM_W'(prod);
      div_den = peak_r;
    end else begin
      div_num = NUM_W'(sum_r) << SCALE_EXTRA_BITS;
      div_den = WEIGHT_W'(count_r);
    end
  end

  cpbq_div #(
    .NUM_W (NUM_W),
    .DEN_W (WEIGHT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_scale | cmd.div_code),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // salient scale, 127 is odd so adding 63 before flooring rounds without ties
  assign sal_num   = (SCLN_W'(peak_r) << SCALE_EXTRA_BITS) + SCLN_W'(CODE_MAX / 2);
  assign sal_prod  = SPROD_W'(sal_num) * SPROD_W'(RECIP);
  assign sal_ext   = SQX_W'(sal_prod[RECIP_SH +: SQ_W]);
  assign sal_scale = (sal_ext > SQX_W'({SCALE_W{1'b1}})) ? {SCALE_W{1'b1}}
                                                         : sal_ext[SCALE_W-1:0];
  assign bin_scale = (div_quo > (NUM_W+1)'({SCALE_W{1'b1}})) ? {SCALE_W{1'b1}}
                                                             : div_quo[SCALE_W-1:0];

  // code selection
  always_comb begin
    q8       = (div_quo > (NUM_W+1)'(CODE_MAX)) ? CODE_W'(CODE_MAX) : div_quo[CODE_W-1:0];
    code_div = rd_neg ? CODE_W'(-q8) : q8;
    if (!mode_r) begin
      code_nxt = rd_neg ? {CODE_W{1'b1}} : CODE_W'(1);
    end else if (peak_r != '0) begin
      code_nxt = code_div;
    end else begin
      code_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale_latch) begin
      scale_r <= mode_r ? sal_scale : bin_scale;
    end
    if (cmd.code_latch) begin
      code_r <= code_nxt;
    end
  end

  assign idx_last = ((CNT_W+1)'(idx_r) + 1'b1) == (CNT_W+1)'(count_r);

  assign sts.col_end  = in_last | (count_r == CNT_W'(COLUMN_MAX - 1));
  assign sts.div_done = div_done;
  assign sts.use_div  = mode_r & (peak_r != '0);
  assign sts.idx_last = idx_last;
  assign sts.sal_mode = mode_r;

  assign out_code      = code_r;
  assign out_scale     = scale_r;
  assign out_position  = POS_W'(idx_r);
  assign out_final_res = idx_last;

endmodule
`default_nettype wire

>>> rtl/core/cpbq_ctrl.sv
`default_nettype none
module cpbq_ctrl import cpbq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_FILL  = 7'b0000001,
    S_SCL   = 7'b0000010,
    S_SCLW  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_CODE  = 7'b0010000,
    S_CODEW = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing of load, scale (divide for binary columns) and per-element code and emit
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.col_end) begin
            state_nxt = S_SCL;
          end
        end
      end
      S_SCL: begin
        // salient scale is ready at once, binary scale needs the divider
        if (sts.sal_mode) begin
          cmd.scale_latch = 1'b1;
          state_nxt       = S_RD;
        end else begin
          cmd.div_scale = 1'b1;
          state_nxt     = S_SCLW;
        end
      end
      S_SCLW: begin
        if (sts.div_done) begin
          cmd.scale_latch = 1'b1;
          state_nxt       = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CODE;
      end
      S_CODE: begin
        if (sts.use_div) begin
          cmd.div_code = 1'b1;
          state_nxt    = S_CODEW;
        end else begin
          cmd.code_latch = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_CODEW: begin
        if (sts.div_done) begin
          cmd.code_latch = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.next  = 1'b1;
          state_nxt = sts.idx_last ? S_FILL : S_RD;
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/column_partial_binarize_quantizer.sv
`default_nettype none
// Column quantizer with partial binarization. Weights of one column are
// taken one per cycle into a buffer until a request with last set arrives
// or COLUMN_MAX weights are held. A salient column gets its scale from a
// reciprocal multiply by 1/127; a binary column gets its mean from the
// shared bit-serial divider (NUM_W = max(23, 21 + SCALE_EXTRA_BITS), 29 at
// the defaults). Then one result request per element is issued in arrival
// order. A binary or all-zero salient column needs no divide per result;
// a salient column with nonzero peak waits for the same divider to form
// each rounded code. Results wait while out_ready is low. Input is not
// taken while a column is being emitted. The salient flag is sampled on
// the first weight of each column.
module column_partial_binarize_quantizer import cpbq_pkg::*; #(
  parameter int COLUMN_MAX       = COLUMN_MAX_DEF,
  parameter int SCALE_EXTRA_BITS = SCALE_EXTRA_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [WEIGHT_W-1:0] in_weight,
  input  wire logic                       in_salient,
  input  wire logic                       in_last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [CODE_W-1:0]        out_code,
  output logic [SCALE_W-1:0]              out_scale,
  output logic [POS_W-1:0]                out_position,
  output logic                            out_final_res
);

  cmd_t cmd;
  sts_t sts;

  cpbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpbq_dp #(
    .COLUMN_MAX       (COLUMN_MAX),
    .SCALE_EXTRA_BITS (SCALE_EXTRA_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_weight     (in_weight),
    .in_salient    (in_salient),
    .in_last       (in_last),
    .cmd           (cmd),
    .sts           (sts),
    .out_code      (out_code),
    .out_scale     (out_scale),
    .out_position  (out_position),
    .out_final_res (out_final_res)
  );

`ifndef SYNTH
  // no loading while a column is being emitted
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken during emit");

  // end of column returns to loading
  a_final_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_final_res |=> in_ready)
    else $error("no return to fill after final result");

  // codes stay symmetric
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code != 8'sh80)
    else $error("code out of range");
`endif

endmodule
`default_nettype wire
